// File: rtl/ppm16_pkg.sv
// Package for the 16-bit PPM stream parser.
// Holds parse phase codes, character constants, result kinds and item types.
// No dependencies.
package ppm16_pkg;

  localparam int DIM_BITS = 16;
  localparam int ACC_W    = 17;
  localparam int COL_W    = 18;

  localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(65536);
  localparam logic [ACC_W-1:0] MAXVAL  = ACC_W'(65535);
  localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((1 << DIM_BITS) - 1);

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [3:0] PH_P     = 4'd0;
  localparam logic [3:0] PH_SIX   = 4'd1;
  localparam logic [3:0] PH_SEP   = 4'd2;
  localparam logic [3:0] PH_WS_W  = 4'd3;
  localparam logic [3:0] PH_TOK_W = 4'd4;
  localparam logic [3:0] PH_WS_H  = 4'd5;
  localparam logic [3:0] PH_TOK_H = 4'd6;
  localparam logic [3:0] PH_WS_M  = 4'd7;
  localparam logic [3:0] PH_TOK_M = 4'd8;
  localparam logic [3:0] PH_DATA  = 4'd9;
  localparam logic [3:0] PH_IDLE  = 4'd10;

  localparam logic [1:0] KIND_HDR_OK  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;
  localparam logic [1:0] KIND_SHORT   = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic       file_start;
    logic [7:0] data_byte;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [15:0] width;
    logic [15:0] height;
    logic        last_sample;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage

// File: rtl/ppm16_if.sv
// Handshake channels of the PPM stream parser: input byte items and result items.
// No dependencies.
interface ppm16_in_if;
  logic       valid;
  logic       ready;
  logic       file_start;
  logic [7:0] data_byte;
  logic       file_end;

  modport source (output valid, output file_start, output data_byte, output file_end,
                  input ready);
  modport sink (input valid, input file_start, input data_byte, input file_end,
                output ready);
endinterface

interface ppm16_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] sample;
  logic [15:0] width;
  logic [15:0] height;
  logic        last_sample;

  modport source (output valid, output kind, output sample, output width, output height,
                  output last_sample, input ready);
  modport sink (input valid, input kind, input sample, input width, input height,
                input last_sample, output ready);
endinterface

// File: rtl/ppm16_core.sv
// Parser state and per-byte step logic: header checks, number parsing, sample pairing.
// Depends on ppm16_pkg.
module ppm16_core import ppm16_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output step_t    step
);

  logic [3:0]       phase, phase_next;
  logic             in_comment, in_comment_next;
  logic             digits_live, digits_live_next;
  logic [ACC_W-1:0] number_acc, number_acc_next;
  logic [15:0]      img_width, img_width_next;
  logic [15:0]      img_height, img_height_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [15:0]      row_count, row_count_next;
  logic [7:0]       high_byte, high_byte_next;
  logic             byte_odd, byte_odd_next;

  logic [3:0]       cur_phase;
  logic             cur_comment, cur_live, cur_odd;
  logic [ACC_W-1:0] cur_acc;
  logic [15:0]      cur_w, cur_h, cur_row;
  logic [COL_W-1:0] cur_col;
  logic [7:0]       cur_high;

  logic [7:0]       b;
  logic             is_ws, is_digit, magic_ok, last;
  logic [3:0]       digit;
  logic [19:0]      acc10;
  logic [ACC_W-1:0] tok_acc, dim_src;
  logic [15:0]      dim_val;
  logic [COL_W-1:0] rowlen, col_inc;
  logic             first_set;
  result_t          first_r, none_r;

  always_comb begin
    cur_phase   = item.file_start ? PH_P : phase;
    cur_comment = item.file_start ? 1'b0 : in_comment;
    cur_live    = item.file_start ? 1'b0 : digits_live;
    cur_acc     = item.file_start ? '0 : number_acc;
    cur_w       = item.file_start ? '0 : img_width;
    cur_h       = item.file_start ? '0 : img_height;
    cur_col     = item.file_start ? '0 : column_count;
    cur_row     = item.file_start ? '0 : row_count;
    cur_high    = item.file_start ? '0 : high_byte;
    cur_odd     = item.file_start ? 1'b0 : byte_odd;

    b        = item.data_byte;
    is_ws    = b <= CH_HASH;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    digit    = 4'(b - CH_ZERO);
    acc10    = {cur_acc, 3'b000} + {2'b00, cur_acc, 1'b0} + {16'd0, digit};
    tok_acc  = (acc10 > {3'b000, ACC_SAT}) ? ACC_SAT : acc10[ACC_W-1:0];
    dim_src  = cur_acc;
    dim_val  = (dim_src > DIM_MAX) ? 16'd0 : dim_src[15:0];
    rowlen   = {1'b0, cur_w, 1'b0} + {2'b00, cur_w};
    col_inc  = cur_col + COL_W'(1);
    last     = (col_inc == rowlen) && ({1'b0, cur_row} + 17'd1 == {1'b0, cur_h});
    magic_ok = 1'b0;

    phase_next        = cur_phase;
    in_comment_next   = cur_comment;
    digits_live_next  = cur_live;
    number_acc_next   = cur_acc;
    img_width_next    = cur_w;
    img_height_next   = cur_h;
    column_count_next = cur_col;
    row_count_next    = cur_row;
    high_byte_next    = cur_high;
    byte_odd_next     = cur_odd;

    none_r    = '0;
    first_r   = '0;
    first_set = 1'b0;

    unique case (cur_phase)
      PH_P, PH_SIX, PH_SEP: begin
        if (cur_phase == PH_P) begin
          magic_ok = b == CH_P;
        end else if (cur_phase == PH_SIX) begin
          magic_ok = b == CH_SIX;
        end else begin
          magic_ok = is_ws;
        end
        if (magic_ok) begin
          phase_next = cur_phase + 4'd1;
        end else begin
          first_set       = 1'b1;
          first_r.kind    = KIND_HDR_BAD;
          phase_next      = PH_IDLE;
        end
      end
      PH_WS_W, PH_WS_H, PH_WS_M: begin
        if (!is_ws && !cur_comment) begin
          phase_next       = cur_phase + 4'd1;
          digits_live_next = is_digit;
          number_acc_next  = is_digit ? ACC_W'(digit) : '0;
        end else if (b == CH_HASH) begin
          in_comment_next = 1'b1;
        end else if (b == CH_CR || b == CH_LF) begin
          in_comment_next = 1'b0;
        end
      end
      PH_TOK_W, PH_TOK_H, PH_TOK_M: begin
        if (!is_ws) begin
          if (cur_live && is_digit) begin
            number_acc_next = tok_acc;
          end else begin
            digits_live_next = 1'b0;
          end
        end else if (cur_phase == PH_TOK_M) begin
          first_set  = 1'b1;
          phase_next = PH_IDLE;
          if (cur_w == '0 || cur_h == '0 || cur_acc != MAXVAL || item.file_end) begin
            first_r.kind = KIND_HDR_BAD;
          end else begin
            first_r.kind      = KIND_HDR_OK;
            first_r.width     = cur_w;
            first_r.height    = cur_h;
            column_count_next = '0;
            row_count_next    = '0;
            byte_odd_next     = 1'b0;
            high_byte_next    = '0;
            phase_next        = PH_DATA;
          end
        end else begin
          if (cur_phase == PH_TOK_W) begin
            img_width_next = dim_val;
          end else begin
            img_height_next = dim_val;
          end
          phase_next      = cur_phase + 4'd1;
          in_comment_next = b == CH_HASH;
        end
      end
      PH_DATA: begin
        if (!cur_odd) begin
          high_byte_next = b;
          byte_odd_next  = 1'b1;
        end else begin
          first_set           = 1'b1;
          first_r.kind        = KIND_SAMPLE;
          first_r.sample      = {cur_high, b};
          first_r.last_sample = last;
          byte_odd_next       = 1'b0;
          if (last) begin
            phase_next = PH_IDLE;
          end else if (col_inc >= rowlen) begin
            column_count_next = '0;
            row_count_next    = cur_row + 16'd1;
          end else begin
            column_count_next = col_inc;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    step = '0;
    if (first_set) begin
      step.r0    = first_r;
      step.count = 2'd1;
    end
    if (item.file_end && phase_next != PH_IDLE) begin
      none_r.kind = (cur_phase == PH_DATA) ? KIND_SHORT : KIND_HDR_BAD;
      phase_next  = PH_IDLE;
      if (first_set) begin
        step.r1    = none_r;
        step.count = 2'd2;
      end else begin
        step.r0    = none_r;
        step.count = 2'd1;
      end
    end
    if (!accept) begin
      step.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_P;
      in_comment   <= 1'b0;
      digits_live  <= 1'b0;
      number_acc   <= '0;
      img_width    <= '0;
      img_height   <= '0;
      column_count <= '0;
      row_count    <= '0;
      high_byte    <= '0;
      byte_odd     <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      in_comment   <= in_comment_next;
      digits_live  <= digits_live_next;
      number_acc   <= number_acc_next;
      img_width    <= img_width_next;
      img_height   <= img_height_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      high_byte    <= high_byte_next;
      byte_odd     <= byte_odd_next;
    end
  end

endmodule

// File: rtl/ppm16_out_fifo.sv
// Result queue: takes up to two result items per cycle, delivers one per handshake.
// Depends on ppm16_pkg.
module ppm16_out_fifo import ppm16_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  step_t   push,
  input  logic    pop,
  output logic    room,
  output logic    valid,
  output result_t head
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign valid = count != '0;
  assign room  = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

endmodule

// File: rtl/ppm16_stream_parser.sv
// Top level of the 16-bit PPM (P6) stream parser.
// The per-byte step logic is combinational; a result item is written into the result queue as its byte is accepted.
// Throughput: one byte per cycle; the 4-entry result queue drops ready while it holds
// more than two items, so a stalled consumer stalls the byte stream.
// Reset: synchronous rst clears parser state and empties the result queue.
// Depends on ppm16_pkg, ppm16_if, ppm16_core and ppm16_out_fifo.
module ppm16_stream_parser import ppm16_pkg::*; (
  input logic        clk,
  input logic        rst,
  ppm16_in_if.sink   byte_stream,
  ppm16_out_if.source result
);

  in_item_t item;
  step_t    step;
  result_t  head;
  logic     accept, room, pop;

  assign item.file_start = byte_stream.file_start;
  assign item.data_byte  = byte_stream.data_byte;
  assign item.file_end   = byte_stream.file_end;

  assign byte_stream.ready = room;
  assign accept            = byte_stream.valid && room;
  assign pop               = result.valid && result.ready;

  ppm16_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .step   (step)
  );

  ppm16_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .pop   (pop),
    .room  (room),
    .valid (result.valid),
    .head  (head)
  );

  assign result.kind        = head.kind;
  assign result.sample      = head.sample;
  assign result.width       = head.width;
  assign result.height      = head.height;
  assign result.last_sample = head.last_sample;

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    step.count != 2'd0 |-> accept)
    else $error("result pushed without an accepted item");

  a_pair_is_sample_short: assert property (@(posedge clk) disable iff (rst)
    step.count == 2'd2 |-> step.r0.kind == KIND_SAMPLE && step.r1.kind == KIND_SHORT)
    else $error("two results from one item other than sample then short");

  a_nonsample_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind != KIND_SAMPLE |->
      result.sample == '0 && !result.last_sample)
    else $error("sample fields set on a non-sample item");

  a_header_dims: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_HDR_OK |-> result.width != '0 && result.height != '0)
    else $error("header accepted with zero dimension");

endmodule

// File: bench/ppm16_score_pkg.sv
// Scoreboard for the 16-bit PPM stream parser bench: parses each accepted byte item
// and checks result items against the queue of results due. Depends on ppm16_pkg.
package ppm16_score_pkg;
  import ppm16_pkg::*;

  class ppm16_scoreboard;
    logic [3:0]       phase;
    logic             in_comment;
    logic             digits_live;
    logic [ACC_W-1:0] number_acc;
    logic [15:0]      img_width;
    logic [15:0]      img_height;
    logic [COL_W-1:0] column_count;
    logic [15:0]      row_count;
    logic [7:0]       high_byte;
    logic             byte_odd;

    result_t due_results[$];
    int      errors;
    int      live_bytes;
    int      kind_seen[4];
    int      closing_samples;

    function new();
      restart();
      errors = 0;
      live_bytes = 0;
      closing_samples = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void restart();
      phase = PH_P;
      in_comment = 1'b0;
      digits_live = 1'b0;
      number_acc = '0;
      img_width = '0;
      img_height = '0;
      column_count = '0;
      row_count = '0;
      high_byte = '0;
      byte_odd = 1'b0;
    endfunction

    function void add_result(logic [1:0] kind, logic [15:0] smp, logic [15:0] w,
                             logic [15:0] h, logic last);
      result_t r;
      r.kind = kind;
      r.sample = smp;
      r.width = w;
      r.height = h;
      r.last_sample = last;
      due_results.push_back(r);
    endfunction

    function logic [15:0] clip_dim(logic [ACC_W-1:0] v);
      return (v > DIM_MAX) ? 16'd0 : v[15:0];
    endfunction

    function void take_digit(logic [7:0] b);
      int v;
      if (digits_live && b >= CH_ZERO && b <= CH_NINE) begin
        v = int'(number_acc) * 10 + int'(b) - int'(CH_ZERO);
        number_acc = (v > int'(ACC_SAT)) ? ACC_SAT : ACC_W'(v);
      end else begin
        digits_live = 1'b0;
      end
    endfunction

    function void skip_white(logic [7:0] b);
      if (b > CH_HASH && !in_comment) begin
        digits_live = 1'b1;
        number_acc = '0;
        phase = phase + 4'd1;
        take_digit(b);
      end else if (b == CH_HASH) begin
        in_comment = 1'b1;
      end else if (b == CH_CR || b == CH_LF) begin
        in_comment = 1'b0;
      end
    endfunction

    function void parse_byte(logic fs, logic [7:0] b, logic fe);
      logic ok;
      logic last;
      int   rowlen;
      if (fs) restart();
      if (phase != PH_IDLE) live_bytes++;
      case (phase)
        PH_P, PH_SIX, PH_SEP: begin
          if (phase == PH_P) ok = (b == CH_P);
          else if (phase == PH_SIX) ok = (b == CH_SIX);
          else ok = (b <= CH_HASH);
          if (ok) begin
            phase = phase + 4'd1;
          end else begin
            add_result(KIND_HDR_BAD, '0, '0, '0, 1'b0);
            phase = PH_IDLE;
          end
        end
        PH_WS_W, PH_WS_H, PH_WS_M: skip_white(b);
        PH_TOK_W, PH_TOK_H: begin
          if (b > CH_HASH) begin
            take_digit(b);
          end else begin
            if (phase == PH_TOK_W) img_width = clip_dim(number_acc);
            else img_height = clip_dim(number_acc);
            phase = phase + 4'd1;
            in_comment = 1'b0;
            skip_white(b);
          end
        end
        PH_TOK_M: begin
          if (b > CH_HASH) begin
            take_digit(b);
          end else if (img_width == 0 || img_height == 0 || number_acc != MAXVAL || fe) begin
            add_result(KIND_HDR_BAD, '0, '0, '0, 1'b0);
            phase = PH_IDLE;
          end else begin
            add_result(KIND_HDR_OK, '0, img_width, img_height, 1'b0);
            column_count = '0;
            row_count = '0;
            byte_odd = 1'b0;
            high_byte = '0;
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (!byte_odd) begin
            high_byte = b;
            byte_odd = 1'b1;
          end else begin
            rowlen = int'(img_width) * 3;
            last = (int'(column_count) + 1 == rowlen) && (int'(row_count) + 1 == int'(img_height));
            add_result(KIND_SAMPLE, {high_byte, b}, '0, '0, last);
            byte_odd = 1'b0;
            if (last) begin
              phase = PH_IDLE;
            end else begin
              column_count = column_count + 1'b1;
              if (int'(column_count) >= rowlen) begin
                column_count = '0;
                row_count = row_count + 16'd1;
              end
            end
          end
          if (fe && phase == PH_DATA) begin
            add_result(KIND_SHORT, '0, '0, '0, 1'b0);
            phase = PH_IDLE;
          end
          return;
        end
        default: phase = PH_IDLE;
      endcase
      if (fe && phase != PH_IDLE) begin
        add_result(KIND_HDR_BAD, '0, '0, '0, 1'b0);
        phase = PH_IDLE;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result item: kind %0d, sample %0h", got.kind, got.sample);
        errors++;
        return;
      end
      want = due_results.pop_front();
      kind_seen[want.kind]++;
      if (want.kind == KIND_SAMPLE && want.last_sample) closing_samples++;
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("sample", want.sample, got.sample);
      compare_field("width", want.width, got.width);
      compare_field("height", want.height, got.height);
      compare_field("last_sample", 16'(want.last_sample), 16'(got.last_sample));
    endfunction
  endclass

endpackage

// File: bench/tb.sv
// Top of the PPM stream parser bench: clock, reset, byte stimulus, result sink and watchdog.
// Depends on ppm16_pkg, ppm16_if, ppm16_score_pkg and the ppm16_stream_parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppm16_pkg::*;
  import ppm16_score_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  ppm16_in_if  byte_if ();
  ppm16_out_if res_if ();

  ppm16_stream_parser DUT (
    .clk(clk),
    .rst(rst),
    .byte_stream(byte_if),
    .result(res_if)
  );

  ppm16_scoreboard sb = new();

  int in_idle_pct;
  int out_idle_pct;
  int hold_asks;
  int holds_done;
  int hold_left;
  int files_sent;
  int stall_cycles;
  int bytes_in;
  logic [7:0] file_bytes[$];

  always #10 clk = ~clk;

  always @(posedge clk) begin
    result_t got;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.kind = res_if.kind;
        got.sample = res_if.sample;
        got.width = res_if.width;
        got.height = res_if.height;
        got.last_sample = res_if.last_sample;
        sb.match_result(got);
      end
      if (byte_if.valid && byte_if.ready) begin
        sb.parse_byte(byte_if.file_start, byte_if.data_byte, byte_if.file_end);
        bytes_in++;
      end
      if ((res_if.valid && res_if.ready) || (byte_if.valid && byte_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ppm16_stream_parser test failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_asks > holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_byte(logic fs, logic [7:0] b, logic fe);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.file_start <= fs;
    byte_if.data_byte <= b;
    byte_if.file_end <= fe;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  task automatic send_file(bit with_end);
    foreach (file_bytes[i])
      send_byte(i == 0, file_bytes[i], with_end && i == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    byte_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  function automatic void put_random(int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_gap(int pieces);
    logic [7:0] c;
    repeat (pieces) begin
      if ($urandom_range(3) == 0) begin
        file_bytes.push_back(CH_HASH);
        repeat ($urandom_range(6)) begin
          c = 8'($urandom_range(255));
          if (c == CH_CR || c == CH_LF) c = 8'h41;
          file_bytes.push_back(c);
        end
        file_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
      end else begin
        file_bytes.push_back(8'($urandom_range(34)));
      end
    end
  endfunction

  function automatic void put_token(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) file_bytes.push_back(CH_ZERO);
    foreach (s[i]) file_bytes.push_back(s[i]);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 2)) file_bytes.push_back(8'($urandom_range(36, 255)));
  endfunction

  function automatic void put_header(int unsigned w, int unsigned h, int unsigned maxv);
    file_bytes.delete();
    file_bytes.push_back(CH_P);
    file_bytes.push_back(CH_SIX);
    file_bytes.push_back(8'($urandom_range(35)));
    put_gap($urandom_range(2));
    put_token(w);
    put_gap($urandom_range(1, 3));
    put_token(h);
    put_gap($urandom_range(1, 3));
    put_token(maxv);
    file_bytes.push_back(8'($urandom_range(35)));
  endfunction

  function automatic int unsigned pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 0;
    if (r < 4) return 65536;
    if (r < 6) return 99999;
    if (r < 16) return $urandom_range(5, 8);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned pick_maxval();
    if ($urandom_range(9) != 0) return 65535;
    case ($urandom_range(3))
      0: return 65534;
      1: return 65536;
      2: return 0;
      default: return 700000;
    endcase
  endfunction

  task automatic random_file();
    int unsigned w;
    int unsigned h;
    int pick;
    int mode;
    int n;
    int cut;
    bit with_end;
    pick = $urandom_range(99);
    with_end = 1'b1;
    if (pick < 70) begin
      w = pick_dim();
      h = pick_dim();
      put_header(w, h, pick_maxval());
      if ($urandom_range(19) == 0) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else begin
        n = (w >= 1 && w <= 8 && h >= 1 && h <= 8) ? int'(w * 3 * h * 2) : 6;
        mode = $urandom_range(19);
        if (mode < 13) put_random(n);
        else if (mode < 16) put_random($urandom_range(0, n - 1));
        else if (mode < 18) put_random(n + $urandom_range(1, 4));
        else if (mode == 19) begin
          put_random(n);
          with_end = 1'b0;
        end
      end
    end else if (pick < 78) begin
      put_header($urandom_range(1, 65535), $urandom_range(1, 65535), 65535);
      put_random($urandom_range(1, 20));
    end else if (pick < 90) begin
      file_bytes = '{CH_P, CH_SIX, 8'($urandom_range(35))};
      case ($urandom_range(2))
        0: file_bytes[0] = CH_P ^ 8'($urandom_range(1, 255));
        1: file_bytes[1] = CH_SIX ^ 8'($urandom_range(1, 255));
        default: file_bytes[2] = 8'($urandom_range(36, 255));
      endcase
      put_random($urandom_range(4));
      with_end = 1'($urandom_range(1));
    end else begin
      repeat ($urandom_range(4, 16))
        send_byte($urandom_range(9) == 0, 8'($urandom_range(255)), $urandom_range(9) == 0);
      files_sent++;
      return;
    end
    send_file(with_end);
  endtask

  initial begin
    rst = 1'b1;
    byte_if.valid = 1'b0;
    byte_if.file_start = 1'b0;
    byte_if.data_byte = '0;
    byte_if.file_end = 1'b0;
    res_if.ready = 1'b0;
    in_idle_pct = 30;
    out_idle_pct = 30;
    hold_asks = 0;
    holds_done = 0;
    hold_left = 0;
    files_sent = 0;
    bytes_in = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    file_bytes = '{8'h51};
    send_file(1'b0);
    file_bytes = '{CH_P, CH_SIX, CH_HASH, "1", " ", "1", " ", "6", "5", "5", "3", "5", " ",
                   8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34};
    send_file(1'b1);
    file_bytes = '{CH_P, 8'h35};
    send_file(1'b0);
    file_bytes = '{CH_P, CH_SIX, 8'h00};
    send_file(1'b1);

    while (bytes_in < ITEM_TARGET) begin
      if (files_sent == 8) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else if (files_sent == 22) begin
        in_idle_pct = 30;
        out_idle_pct = 30;
      end
      if (files_sent == 25 || files_sent == 60) hold_asks++;
      if (files_sent % 15 == 14) drain_results();
      random_file();
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d byte items (%0d parsed) in %0d files, with random gaps and stalls.",
             bytes_in, sb.live_bytes, files_sent);
    $display("Results: %0d headers accepted, %0d rejected, %0d samples (%0d closing), %0d short.",
             sb.kind_seen[KIND_HDR_OK], sb.kind_seen[KIND_HDR_BAD], sb.kind_seen[KIND_SAMPLE],
             sb.closing_samples, sb.kind_seen[KIND_SHORT]);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("ppm16_stream_parser test passed");
    end else begin
      $display("ppm16_stream_parser test failed");
    end
    $finish;
  end

endmodule
